FILE: sv/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HALF_PERIOD    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACK_POLL_LIMIT = 2'd2;

   localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd88;
   localparam logic [15:0] HALF_PERIOD_RESET    = 16'd20;
   localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd250;

   // request commands
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
   localparam logic [2:0] READ_BYTES     = 3'd5;
   localparam logic [2:0] LAST_READ_BYTE = 3'd4;
   localparam logic [2:0] CRC_BYTE       = 3'd2;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_START_A   = 5'd1,
      PH_START_B   = 5'd2,
      PH_TX_LOW    = 5'd3,
      PH_TX_HIGH   = 5'd4,
      PH_ACK_LOW   = 5'd5,
      PH_ACK_HIGH  = 5'd6,
      PH_RX_LOW    = 5'd7,
      PH_RX_HIGH   = 5'd8,
      PH_MACK_LOW  = 5'd9,
      PH_MACK_HIGH = 5'd10,
      PH_STOP_A    = 5'd11,
      PH_STOP_B    = 5'd12,
      PH_STOP_C    = 5'd13
   } phase_type;

   typedef struct packed {
      logic [6:0]  device_address;
      logic [15:0] half_period_ticks;
      logic [7:0]  ack_poll_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] command_high;
      logic [7:0] command_low;
      logic       sda_sample;
   } req_item_type;

   typedef struct packed {
      logic        scl_level;
      logic        sda_level;
      logic        sda_enable;
      logic        busy_res;
      logic        done_res;
      logic        ack_error;
      logic [31:0] read_value;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: sv/i2cm_req_if.sv
`default_nettype none

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] command_high;
   logic [7:0] command_low;
   logic       sda_sample;

   modport source (output valid, cmd, command_high, command_low, sda_sample, input ready);
   modport sink   (input valid, cmd, command_high, command_low, sda_sample, output ready);
endinterface

`default_nettype wire

FILE: sv/i2cm_rsp_if.sv
`default_nettype none

interface i2cm_rsp_if;
   logic        valid;
   logic        ready;
   logic        scl_level;
   logic        sda_level;
   logic        sda_enable;
   logic        busy_res;
   logic        done_res;
   logic        ack_error;
   logic [31:0] read_value;

   modport source (output valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                   ack_error, read_value, input ready);
   modport sink   (input valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                   ack_error, read_value, output ready);
endinterface

`default_nettype wire

FILE: sv/i2cm_csr_if.sv
`default_nettype none

interface i2cm_csr_if import i2cm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/i2cm_cfg_regs.sv
`default_nettype none

module i2cm_cfg_regs import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   i2cm_csr_if.sink   csr,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            REG_DEVICE_ADDRESS: cfg_in.device_address    = csr.data[6:0];
            REG_HALF_PERIOD:    cfg_in.half_period_ticks = csr.data[15:0];
            REG_ACK_POLL_LIMIT: cfg_in.ack_poll_limit    = csr.data[7:0];
            default: ;  // drop writes outside the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address    <= DEVICE_ADDRESS_RESET;
         cfg_ff.half_period_ticks <= HALF_PERIOD_RESET;
         cfg_ff.ack_poll_limit    <= ACK_POLL_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/i2cm_engine.sv
`default_nettype none

module i2cm_engine import i2cm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [2:0]  byte_count_ff, byte_count_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [15:0] delay_count_ff, delay_count_in;
   logic [7:0]  ack_poll_ff, ack_poll_in;
   logic [31:0] value_ff, value_in;
   logic [15:0] pending_ff, pending_in;
   logic        error_ff, error_in;
   logic        read_mode_ff, read_mode_in;

   logic [15:0] half_ticks;
   logic [15:0] delay_inc;
   logic        timed_done;
   logic [15:0] timed_delay;
   logic [15:0] ack_delay;
   logic [3:0]  bit_inc;
   logic [2:0]  byte_inc;
   logic [8:0]  poll_inc;
   logic [7:0]  rx_shift;
   logic        start_cmd;
   logic        done_pulse;
   logic        scl, sda, sda_en;

   assign half_ticks  = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
   assign delay_inc   = delay_count_ff + 16'd1;
   assign timed_done  = (delay_inc >= half_ticks);
   assign timed_delay = timed_done ? 16'd0 : delay_inc;
   // the ACK phase counts up to the half period and then holds there while polling
   assign ack_delay   = (delay_count_ff < half_ticks) ? delay_inc : delay_count_ff;
   assign bit_inc     = bit_count_ff + 4'd1;
   assign byte_inc    = byte_count_ff + 3'd1;
   assign poll_inc    = {1'b0, ack_poll_ff} + 9'd1;
   // sample the read bit on the first tick of SCL high
   assign rx_shift    = (delay_count_ff == 16'd0) ? {shift_byte_ff[6:0], item.sda_sample}
                                                  : shift_byte_ff;
   assign start_cmd   = (item.cmd == CMD_WRITE) || (item.cmd == CMD_READ);

   // line levels for the phase this tick is spent in
   always_comb begin
      scl    = 1'b1;
      sda    = 1'b1;
      sda_en = 1'b0;
      unique case (phase_ff)
         PH_START_A:   sda_en = 1'b1;
         PH_START_B:   begin sda = 1'b0; sda_en = 1'b1; end
         PH_TX_LOW:    begin scl = 1'b0; sda = shift_byte_ff[7]; sda_en = 1'b1; end
         PH_TX_HIGH:   begin sda = shift_byte_ff[7]; sda_en = 1'b1; end
         PH_ACK_LOW:   scl = 1'b0;
         PH_RX_LOW:    scl = 1'b0;
         PH_MACK_LOW:  begin
            scl    = 1'b0;
            sda    = (byte_count_ff == LAST_READ_BYTE);
            sda_en = 1'b1;
         end
         PH_MACK_HIGH: begin sda = (byte_count_ff == LAST_READ_BYTE); sda_en = 1'b1; end
         PH_STOP_A:    begin scl = 1'b0; sda = 1'b0; sda_en = 1'b1; end
         PH_STOP_B:    begin sda = 1'b0; sda_en = 1'b1; end
         PH_STOP_C:    sda_en = 1'b1;
         default: ;    // idle, ACK high and read high release SDA with SCL high
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      byte_count_in  = byte_count_ff;
      shift_byte_in  = shift_byte_ff;
      delay_count_in = delay_count_ff;
      ack_poll_in    = ack_poll_ff;
      value_in       = value_ff;
      pending_in     = pending_ff;
      error_in       = error_ff;
      read_mode_in   = read_mode_ff;
      done_pulse     = 1'b0;

      unique case (phase_ff)
         PH_START_A: begin
            delay_count_in = timed_delay;
            if (timed_done) phase_in = PH_START_B;
         end
         PH_START_B: begin
            delay_count_in = timed_delay;
            if (timed_done) begin
               bit_count_in = 4'd0;
               phase_in     = PH_TX_LOW;
            end
         end
         PH_TX_LOW: begin
            delay_count_in = timed_delay;
            if (timed_done) phase_in = PH_TX_HIGH;
         end
         PH_TX_HIGH: begin
            delay_count_in = timed_delay;
            if (timed_done) begin
               shift_byte_in = {shift_byte_ff[6:0], 1'b0};
               bit_count_in  = bit_inc;
               if (bit_inc >= BITS_PER_BYTE) begin
                  ack_poll_in = 8'd0;
                  phase_in    = PH_ACK_LOW;
               end else begin
                  phase_in = PH_TX_LOW;
               end
            end
         end
         PH_ACK_LOW: begin
            delay_count_in = timed_delay;
            if (timed_done) phase_in = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: begin
            delay_count_in = ack_delay;
            if (ack_delay >= half_ticks) begin
               if (!item.sda_sample) begin
                  byte_count_in  = byte_inc;
                  bit_count_in   = 4'd0;
                  delay_count_in = 16'd0;
                  if (read_mode_ff) begin
                     byte_count_in = 3'd0;
                     shift_byte_in = 8'd0;
                     phase_in      = PH_RX_LOW;
                  end else if (byte_inc == 3'd1) begin
                     shift_byte_in = pending_ff[15:8];
                     phase_in      = PH_TX_LOW;
                  end else if (byte_inc == 3'd2) begin
                     shift_byte_in = pending_ff[7:0];
                     phase_in      = PH_TX_LOW;
                  end else begin
                     phase_in = PH_STOP_A;
                  end
               end else if (poll_inc > {1'b0, cfg.ack_poll_limit}) begin
                  // give up on the target: flag it and release the bus
                  error_in       = 1'b1;
                  delay_count_in = 16'd0;
                  phase_in       = PH_STOP_A;
               end else begin
                  ack_poll_in = poll_inc[7:0];
               end
            end
         end
         PH_RX_LOW: begin
            delay_count_in = timed_delay;
            if (timed_done) phase_in = PH_RX_HIGH;
         end
         PH_RX_HIGH: begin
            shift_byte_in  = rx_shift;
            delay_count_in = timed_delay;
            if (timed_done) begin
               bit_count_in = bit_inc;
               if (bit_inc >= BITS_PER_BYTE) begin
                  // skip the CRC byte
                  if (byte_count_ff != CRC_BYTE) value_in = {value_ff[23:0], rx_shift};
                  phase_in = PH_MACK_LOW;
               end else begin
                  phase_in = PH_RX_LOW;
               end
            end
         end
         PH_MACK_LOW: begin
            delay_count_in = timed_delay;
            if (timed_done) phase_in = PH_MACK_HIGH;
         end
         PH_MACK_HIGH: begin
            delay_count_in = timed_delay;
            if (timed_done) begin
               byte_count_in = byte_inc;
               bit_count_in  = 4'd0;
               shift_byte_in = 8'd0;
               phase_in      = (byte_inc >= READ_BYTES) ? PH_STOP_A : PH_RX_LOW;
            end
         end
         PH_STOP_A: begin
            delay_count_in = timed_delay;
            if (timed_done) phase_in = PH_STOP_B;
         end
         PH_STOP_B: begin
            delay_count_in = timed_delay;
            if (timed_done) phase_in = PH_STOP_C;
         end
         PH_STOP_C: begin
            delay_count_in = timed_delay;
            if (timed_done) begin
               done_pulse = 1'b1;
               phase_in   = PH_IDLE;
            end
         end
         default: begin
            // idle: start a transaction on a write or read command
            phase_in = PH_IDLE;
            if (start_cmd) begin
               read_mode_in   = (item.cmd == CMD_READ);
               pending_in     = {item.command_high, item.command_low};
               error_in       = 1'b0;
               byte_count_in  = 3'd0;
               bit_count_in   = 4'd0;
               shift_byte_in  = {cfg.device_address, (item.cmd == CMD_READ)};
               delay_count_in = 16'd0;
               phase_in       = PH_START_A;
            end
         end
      endcase
   end

   always_comb begin
      result.scl_level  = scl;
      result.sda_level  = sda;
      result.sda_enable = sda_en;
      result.busy_res   = (phase_ff != PH_IDLE);
      result.done_res   = done_pulse;
      result.ack_error  = error_in;
      result.read_value = value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= 4'd0;
         byte_count_ff  <= 3'd0;
         shift_byte_ff  <= 8'd0;
         delay_count_ff <= 16'd0;
         ack_poll_ff    <= 8'd0;
         value_ff       <= 32'd0;
         pending_ff     <= 16'd0;
         error_ff       <= 1'b0;
         read_mode_ff   <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         byte_count_ff  <= byte_count_in;
         shift_byte_ff  <= shift_byte_in;
         delay_count_ff <= delay_count_in;
         ack_poll_ff    <= ack_poll_in;
         value_ff       <= value_in;
         pending_ff     <= pending_in;
         error_ff       <= error_in;
         read_mode_ff   <= read_mode_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/i2c_sensor_transaction_master.sv
// I2C master for a two-wire sensor, advanced by one request per bus tick. Each request carries
// a command (tick, write, read), the two command bytes of a write and the sampled SDA level;
// each yields exactly one response with the SCL/SDA drive for that tick, busy, a done pulse,
// the missing-ACK flag and the 32-bit value of the last read. A request is taken every cycle
// while responses are not stalled. It lands in an input register; once the response register
// is free, the bus sequencer updates its state once for it and the response register loads.
// A stalled response holds both registers and, while the input register is full, drops the
// request ready until it is taken. Write the configuration registers (device address, half
// period in ticks, ACK poll limit) only while the bus is idle and no response is outstanding.
`default_nettype none

module i2c_sensor_transaction_master import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   i2cm_req_if.sink   req_chan,
   i2cm_rsp_if.source rsp_chan,
   i2cm_csr_if.sink   csr_chan
);

   cfg_type      cfg;
   req_item_type req_item_ff, req_item_in;
   logic         req_valid_ff, req_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type step_result;
   logic         rsp_open;
   logic         step;
   logic         req_take;

   i2cm_cfg_regs u_cfg_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   i2cm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   assign rsp_open       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = req_valid_ff && rsp_open;
   assign req_chan.ready = !req_valid_ff || rsp_open;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      req_valid_in = req_take || (req_valid_ff && !step);
      req_item_in  = req_item_ff;
      if (req_take) begin
         req_item_in.cmd          = req_chan.cmd;
         req_item_in.command_high = req_chan.command_high;
         req_item_in.command_low  = req_chan.command_low;
         req_item_in.sda_sample   = req_chan.sda_sample;
      end
      // hold the response until taken
      rsp_valid_in = step || (rsp_valid_ff && !rsp_chan.ready);
      rsp_item_in  = step ? step_result : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.scl_level  = rsp_item_ff.scl_level;
   assign rsp_chan.sda_level  = rsp_item_ff.sda_level;
   assign rsp_chan.sda_enable = rsp_item_ff.sda_enable;
   assign rsp_chan.busy_res   = rsp_item_ff.busy_res;
   assign rsp_chan.done_res   = rsp_item_ff.done_res;
   assign rsp_chan.ack_error  = rsp_item_ff.ack_error;
   assign rsp_chan.read_value = rsp_item_ff.read_value;

endmodule

`default_nettype wire

FILE: sv/i2cm_checker.sv
`default_nettype none

module i2cm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        scl_level,
   input logic        sda_level,
   input logic        sda_enable,
   input logic        busy_res,
   input logic        done_res,
   input logic        ack_error,
   input logic [31:0] read_value
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(scl_level) && $stable(sda_level)
         && $stable(sda_enable) && $stable(busy_res) && $stable(done_res)
         && $stable(ack_error) && $stable(read_value))
      else $error("response changed while stalled");

   // an idle master leaves the bus released with SCL high
   a_idle_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy_res |-> scl_level && sda_level && !sda_enable && !done_res)
      else $error("bus not released while idle");

   // the done pulse lands on the final tick of STOP, both lines high
   a_done_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> busy_res && scl_level && sda_level && sda_enable)
      else $error("done outside the end of STOP");

   // released SDA always reads as level high
   a_released_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !sda_enable |-> sda_level)
      else $error("released SDA shows a low level");

endmodule

bind i2c_sensor_transaction_master i2cm_checker u_i2cm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .scl_level  (rsp_chan.scl_level),
   .sda_level  (rsp_chan.sda_level),
   .sda_enable (rsp_chan.sda_enable),
   .busy_res   (rsp_chan.busy_res),
   .done_res   (rsp_chan.done_res),
   .ack_error  (rsp_chan.ack_error),
   .read_value (rsp_chan.read_value)
);

`default_nettype wire

FILE: verif/i2c_sensor_transaction_master_tb.sv
module i2c_sensor_transaction_master_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cm_pkg::*;

   localparam int CYCLE_LIMIT  = 500_000;
   localparam int RANDOM_TICKS = 150;
   // decoded by the block as a plain tick
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef enum int {ACK_PROMPT, ACK_SLOW, ACK_NONE} target_ack_type;

   logic clock;
   logic reset;

   i2cm_req_if req_bus();
   i2cm_rsp_if rsp_bus();
   i2cm_csr_if csr_bus();

   i2c_sensor_transaction_master i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // register copies
   logic [6:0]  addr_reg       = DEVICE_ADDRESS_RESET;
   logic [15:0] half_reg       = HALF_PERIOD_RESET;
   logic [7:0]  poll_limit_reg = ACK_POLL_LIMIT_RESET;

   // bus sequencer state
   phase_type   bus_phase = PH_IDLE;
   logic [3:0]  bit_cnt   = '0;
   logic [2:0]  byte_cnt  = '0;
   logic [7:0]  shift_reg = '0;
   logic [15:0] delay_cnt = '0;
   logic [7:0]  poll_cnt  = '0;
   logic [31:0] value_acc = '0;
   logic [15:0] cmd_bytes = '0;
   logic        err_flag  = 1'b0;
   logic        read_dir  = 1'b0;

   rsp_item_type bus_outputs_q[$];
   int error_count = 0;
   int cycle_count = 0;
   int busy_ticks  = 0;
   bit gaps_on     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] phase_len();
      return (half_reg == 16'd0) ? 16'd1 : half_reg;
   endfunction

   function automatic void enter_phase(phase_type ph);
      bus_phase = ph;
      delay_cnt = '0;
   endfunction

   // count one tick of a timed phase; true once the phase has run its length
   function automatic bit phase_over();
      delay_cnt = delay_cnt + 16'd1;
      if (delay_cnt >= phase_len()) begin
         delay_cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void take_ack();
      byte_cnt = byte_cnt + 3'd1;
      bit_cnt  = '0;
      if (read_dir) begin
         byte_cnt  = '0;
         shift_reg = '0;
         enter_phase(PH_RX_LOW);
      end else if (byte_cnt == 3'd1) begin
         shift_reg = cmd_bytes[15:8];
         enter_phase(PH_TX_LOW);
      end else if (byte_cnt == 3'd2) begin
         shift_reg = cmd_bytes[7:0];
         enter_phase(PH_TX_LOW);
      end else begin
         enter_phase(PH_STOP_A);
      end
   endfunction

   // one bus tick: line drive of the current phase, then advance the sequencer
   function automatic rsp_item_type step_sequencer(req_item_type rq);
      rsp_item_type o;
      logic         mack;
      o = '0;
      mack = (byte_cnt == LAST_READ_BYTE);
      o.scl_level  = 1'b1;
      o.sda_level  = 1'b1;
      o.sda_enable = 1'b0;
      case (bus_phase)
         PH_START_A: o.sda_enable = 1'b1;
         PH_START_B: begin
            o.sda_level  = 1'b0;
            o.sda_enable = 1'b1;
         end
         PH_TX_LOW: begin
            o.scl_level  = 1'b0;
            o.sda_level  = shift_reg[7];
            o.sda_enable = 1'b1;
         end
         PH_TX_HIGH: begin
            o.sda_level  = shift_reg[7];
            o.sda_enable = 1'b1;
         end
         PH_ACK_LOW, PH_RX_LOW: o.scl_level = 1'b0;
         PH_MACK_LOW: begin
            o.scl_level  = 1'b0;
            o.sda_level  = mack;
            o.sda_enable = 1'b1;
         end
         PH_MACK_HIGH: begin
            o.sda_level  = mack;
            o.sda_enable = 1'b1;
         end
         PH_STOP_A: begin
            o.scl_level  = 1'b0;
            o.sda_level  = 1'b0;
            o.sda_enable = 1'b1;
         end
         PH_STOP_B: begin
            o.sda_level  = 1'b0;
            o.sda_enable = 1'b1;
         end
         PH_STOP_C: o.sda_enable = 1'b1;
         default: ;
      endcase
      o.busy_res = (bus_phase != PH_IDLE);

      case (bus_phase)
         PH_IDLE: begin
            if (rq.cmd == CMD_WRITE || rq.cmd == CMD_READ) begin
               read_dir  = (rq.cmd == CMD_READ);
               cmd_bytes = {rq.command_high, rq.command_low};
               err_flag  = 1'b0;
               byte_cnt  = '0;
               bit_cnt   = '0;
               shift_reg = {addr_reg, read_dir};
               enter_phase(PH_START_A);
            end
         end
         PH_START_A: if (phase_over()) enter_phase(PH_START_B);
         PH_START_B: if (phase_over()) begin
            bit_cnt = '0;
            enter_phase(PH_TX_LOW);
         end
         PH_TX_LOW: if (phase_over()) enter_phase(PH_TX_HIGH);
         PH_TX_HIGH: if (phase_over()) begin
            shift_reg = {shift_reg[6:0], 1'b0};
            bit_cnt   = bit_cnt + 4'd1;
            if (bit_cnt >= BITS_PER_BYTE) begin
               poll_cnt = '0;
               enter_phase(PH_ACK_LOW);
            end else begin
               enter_phase(PH_TX_LOW);
            end
         end
         PH_ACK_LOW: if (phase_over()) enter_phase(PH_ACK_HIGH);
         PH_ACK_HIGH: begin
            // hold SCL high a full half period, then poll once per tick
            if (delay_cnt < phase_len()) delay_cnt = delay_cnt + 16'd1;
            if (delay_cnt >= phase_len()) begin
               if (!rq.sda_sample) begin
                  take_ack();
               end else if (int'(poll_cnt) + 1 > int'(poll_limit_reg)) begin
                  err_flag = 1'b1;
                  enter_phase(PH_STOP_A);
               end else begin
                  poll_cnt = poll_cnt + 8'd1;
               end
            end
         end
         PH_RX_LOW: if (phase_over()) enter_phase(PH_RX_HIGH);
         PH_RX_HIGH: begin
            if (delay_cnt == 16'd0) shift_reg = {shift_reg[6:0], rq.sda_sample};
            if (phase_over()) begin
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= BITS_PER_BYTE) begin
                  // drop the CRC byte
                  if (byte_cnt != CRC_BYTE) value_acc = {value_acc[23:0], shift_reg};
                  enter_phase(PH_MACK_LOW);
               end else begin
                  enter_phase(PH_RX_LOW);
               end
            end
         end
         PH_MACK_LOW: if (phase_over()) enter_phase(PH_MACK_HIGH);
         PH_MACK_HIGH: if (phase_over()) begin
            byte_cnt  = byte_cnt + 3'd1;
            bit_cnt   = '0;
            shift_reg = '0;
            enter_phase((byte_cnt >= READ_BYTES) ? PH_STOP_A : PH_RX_LOW);
         end
         PH_STOP_A: if (phase_over()) enter_phase(PH_STOP_B);
         PH_STOP_B: if (phase_over()) enter_phase(PH_STOP_C);
         PH_STOP_C: if (phase_over()) begin
            o.done_res = 1'b1;
            enter_phase(PH_IDLE);
         end
         default: ;
      endcase
      o.ack_error  = err_flag;
      o.read_value = value_acc;
      return o;
   endfunction

   // SDA level the sensor puts on the line for the tick about to be sent
   function automatic logic target_sda(target_ack_type style, int one_pct);
      if (bus_phase == PH_ACK_HIGH) begin
         case (style)
            ACK_PROMPT: return 1'b0;
            ACK_SLOW:   return ($urandom_range(0, 3) != 0);
            default:    return 1'b1;
         endcase
      end
      return ($urandom_range(0, 99) < one_pct);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   task automatic send_request(input req_item_type rq);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= rq.cmd;
      req_bus.command_high <= rq.command_high;
      req_bus.command_low  <= rq.command_low;
      req_bus.sda_sample   <= rq.sda_sample;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (bus_phase != PH_IDLE || rq.cmd == CMD_WRITE || rq.cmd == CMD_READ) busy_ticks++;
      bus_outputs_q.push_back(step_sequencer(rq));
   endtask

   task automatic idle_ticks(input int n);
      req_item_type rq;
      repeat (n) begin
         rq.cmd          = ($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_SPARE;
         rq.command_high = 8'($urandom);
         rq.command_low  = 8'($urandom);
         rq.sda_sample   = 1'($urandom);
         send_request(rq);
      end
   endtask

   // start a transfer from an idle bus and tick until the bus is idle again
   task automatic run_transfer(input logic [1:0] cmd, input logic [7:0] hi,
                               input logic [7:0] lo, input target_ack_type style,
                               input int one_pct);
      req_item_type rq;
      rq.cmd          = cmd;
      rq.command_high = hi;
      rq.command_low  = lo;
      rq.sda_sample   = target_sda(style, one_pct);
      send_request(rq);
      while (bus_phase != PH_IDLE) begin
         // commands while busy must be ignored
         rq.cmd          = 2'($urandom);
         rq.command_high = 8'($urandom);
         rq.command_low  = 8'($urandom);
         rq.sda_sample   = target_sda(style, one_pct);
         send_request(rq);
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         REG_DEVICE_ADDRESS: addr_reg = val[6:0];
         REG_HALF_PERIOD:    half_reg = val;
         REG_ACK_POLL_LIMIT: poll_limit_reg = val[7:0];
         default: ;
      endcase
   endtask

   // drain all responses from an idle bus, then rewrite every register
   task automatic configure(input logic [6:0] addr, input logic [15:0] half,
                            input logic [7:0] lim);
      req_bus.valid <= 1'b0;
      while (bus_outputs_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(REG_DEVICE_ADDRESS, {9'd0, addr});
      csr_write(REG_HALF_PERIOD, half);
      csr_write(REG_ACK_POLL_LIMIT, {8'd0, lim});
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_reset_values();
      idle_ticks(6);
      // keep the reset address and poll limit, shorten the bit time
      req_bus.valid <= 1'b0;
      while (bus_outputs_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(REG_HALF_PERIOD, 16'd1);
      csr_bus.valid <= 1'b0;
      run_transfer(CMD_WRITE, 8'hA5, 8'h3C, ACK_PROMPT, 50);
   endtask

   task automatic test_field_extremes();
      configure(7'h7F, 16'd1, 8'd1);
      run_transfer(CMD_WRITE, 8'h00, 8'hFF, ACK_PROMPT, 50);
      run_transfer(CMD_READ, 8'hFF, 8'h00, ACK_PROMPT, 100);
      // zero half period runs like one
      configure(7'h00, 16'd0, 8'd255);
      run_transfer(CMD_WRITE, 8'hFF, 8'h00, ACK_PROMPT, 50);
      run_transfer(CMD_READ, 8'h00, 8'hFF, ACK_PROMPT, 0);
   endtask

   task automatic test_missing_ack();
      configure(7'h2A, 16'd2, 8'd1);
      run_transfer(CMD_WRITE, 8'h12, 8'h34, ACK_NONE, 50);
      run_transfer(CMD_READ, 8'h56, 8'h78, ACK_NONE, 50);
      run_transfer(CMD_WRITE, 8'hDE, 8'hF0, ACK_SLOW, 50);
      configure(7'h55, 16'd1, 8'd255);
      run_transfer(CMD_WRITE, 8'($urandom), 8'($urandom), ACK_NONE, 50);
   endtask

   task automatic test_random_traffic();
      int             pick;
      int             one_pct;
      logic [15:0]    half;
      logic [7:0]     lim;
      target_ack_type style;
      busy_ticks = 0;
      while (busy_ticks < RANDOM_TICKS) begin
         gaps_on = (busy_ticks < RANDOM_TICKS * 3 / 4) && ($urandom_range(0, 3) != 0);
         half = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(2, 4)) : 16'd1;
         pick = $urandom_range(0, 9);
         lim  = (pick < 3) ? 8'($urandom_range(1, 3)) :
                (pick == 3) ? 8'd255 : 8'($urandom_range(4, 254));
         configure(7'($urandom), half, lim);
         repeat ($urandom_range(2, 4)) begin
            idle_ticks($urandom_range(0, 3));
            pick  = $urandom_range(0, 9);
            style = (pick < 6) ? ACK_PROMPT : (pick < 9) ? ACK_SLOW : ACK_NONE;
            one_pct = ($urandom_range(0, 4) == 0) ? 100 * $urandom_range(0, 1) : 50;
            run_transfer(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_WRITE,
                         8'($urandom), 8'($urandom), style, one_pct);
         end
      end
      gaps_on = 1'b0;
   endtask

   task automatic test_long_half_period();
      req_item_type rq;
      gaps_on = 1'b0;
      configure(7'($urandom), 16'hFFFF, 8'($urandom_range(1, 255)));
      idle_ticks(4);
      rq.cmd          = CMD_WRITE;
      rq.command_high = 8'($urandom);
      rq.command_low  = 8'($urandom);
      rq.sda_sample   = 1'b1;
      send_request(rq);
      // the bus stays in the start condition for the whole stretch
      repeat (100) begin
         rq.cmd          = 2'($urandom);
         rq.command_high = 8'($urandom);
         rq.command_low  = 8'($urandom);
         rq.sda_sample   = 1'($urandom);
         send_request(rq);
      end
   endtask

   initial begin
      forever begin
         if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (bus_outputs_q.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = bus_outputs_q.pop_front();
            check_field("scl_level", want.scl_level, rsp_bus.scl_level);
            check_field("sda_level", want.sda_level, rsp_bus.sda_level);
            check_field("sda_enable", want.sda_enable, rsp_bus.sda_enable);
            check_field("busy_res", want.busy_res, rsp_bus.busy_res);
            check_field("done_res", want.done_res, rsp_bus.done_res);
            check_field("ack_error", want.ack_error, rsp_bus.ack_error);
            check_field("read_value", want.read_value, rsp_bus.read_value);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.cmd          <= CMD_TICK;
      req_bus.command_high <= '0;
      req_bus.command_low  <= '0;
      req_bus.sda_sample   <= 1'b1;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= REG_DEVICE_ADDRESS;
      csr_bus.data         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      gaps_on = 1'b1;
      test_field_extremes();
      test_missing_ack();
      test_random_traffic();
      test_long_half_period();
      req_bus.valid <= 1'b0;
      while (bus_outputs_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
